/* hdl/bsc_pkg.sv */
// Shared types, constants and register codes of the barometer compensation block.
`timescale 1ns / 1ps

package bsc_pkg;

    // Field widths of the stream words
    localparam int RAW_TEMP_W  = 16;
    localparam int RAW_PRESS_W = 19;
    localparam int TEMP_W      = 16;
    localparam int PRESS_W     = 20;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 40;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAL_A = 2'd0,
        CFG_CAL_B = 2'd1,
        CFG_CAL_C = 2'd2,
        CFG_OSS   = 2'd3
    } cfg_addr_t;

    // Compensation constants
    localparam int            B6_OFFSET   = 4000;
    localparam int            B4_OFFSET   = 32768;
    localparam logic [15:0]   B7_SCALE    = 16'd50000;
    localparam logic [47:0]   B7_LIMIT    = 48'h0000_8000_0000;
    localparam int            P_C1        = 3038;
    localparam int            P_C2        = -7357;
    localparam int            P_C3        = 3791;
    localparam logic [PRESS_W-1:0] PRESS_MAX = 20'hFFFFF;

    // Shared divider geometry
    localparam int DIV_NUM_W       = 48;
    localparam int DIV_DEN_W       = 33;
    localparam int DIV_CNT_W       = $clog2(DIV_NUM_W + 1);
    localparam int TEMP_DIV_STEPS  = 27;
    localparam int PRESS_DIV_STEPS = 48;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Decoded calibration set
    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic        [15:0] ac4;
        logic        [15:0] ac5;
        logic        [15:0] ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic        [1:0]  oss;
    } cal_t;

    // One queued reading
    typedef struct packed {
        logic [RAW_TEMP_W-1:0]  raw_temp;
        logic [RAW_PRESS_W-1:0] raw_press;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

/* hdl/bsc_fifo.sv */
// Two-entry queue that carries readings from the front to the back.
`timescale 1ns / 1ps

module bsc_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  bsc_pkg::item_t wr_data,
    input  logic           rd_en,
    output bsc_pkg::item_t rd_data,
    output bsc_pkg::q_stat_t stat
);
    import bsc_pkg::*;

    item_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign stat.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem[rd_ptr_reg];

    // Store incoming words
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (!wr_en && rd_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !wr_en || rd_en)
        else $error("queue written while full");

    a_no_underflow : assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !stat.empty)
        else $error("queue read while empty");
`endif

endmodule

/* hdl/bsc_front.sv */
// Front end: configuration registers, coefficient unpacking and input acceptance.
`timescale 1ns / 1ps

module bsc_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bsc_pkg::S_DATA_W-1:0]          s_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [bsc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  bsc_pkg::q_stat_t                      q_stat,
    output logic                                  q_wr_en,
    output bsc_pkg::item_t                        q_wr_data,
    output bsc_pkg::cal_t                         cal
);
    import bsc_pkg::*;

    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_CAL_A: cal_a_reg <= cfg_wdata;
                CFG_CAL_B: cal_b_reg <= cfg_wdata;
                CFG_CAL_C: cal_c_reg <= cfg_wdata[31:0];
                CFG_OSS:   oss_reg   <= cfg_wdata[1:0];
                default:   ;
            endcase
        end
    end

    // Unpack coefficients
    assign cal.ac1 = $signed(cal_a_reg[63:48]);
    assign cal.ac2 = $signed(cal_a_reg[47:32]);
    assign cal.ac3 = $signed(cal_a_reg[31:16]);
    assign cal.ac4 = cal_a_reg[15:0];
    assign cal.ac5 = cal_b_reg[63:48];
    assign cal.ac6 = cal_b_reg[47:32];
    assign cal.b1  = $signed(cal_b_reg[31:16]);
    assign cal.b2  = $signed(cal_b_reg[15:0]);
    assign cal.mc  = $signed(cal_c_reg[31:16]);
    assign cal.md  = $signed(cal_c_reg[15:0]);
    assign cal.oss = oss_reg;

    // Accept words while the queue has room
    assign s_tready            = !q_stat.full;
    assign q_wr_en             = s_tvalid && !q_stat.full;
    assign q_wr_data.raw_temp  = s_tdata[RAW_TEMP_W-1:0];
    assign q_wr_data.raw_press = s_tdata[RAW_TEMP_W+RAW_PRESS_W-1:RAW_TEMP_W];

endmodule

/* hdl/bsc_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bsc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bsc_pkg::div_req_t req,
    output bsc_pkg::div_rsp_t rsp
);
    import bsc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;

    logic [DIV_DEN_W:0]   shifted;
    logic                 fits;

    // Trial subtract of the next partial remainder
    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift in one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= req.num;
        end else if (busy_reg) begin
            rem_reg <= fits ? DIV_DEN_W'(shifted - {1'b0, den_reg}) : DIV_DEN_W'(shifted);
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* hdl/bsc_core.sv */
// Back end: compensation sequencer with one shared multiplier and the result register.
`timescale 1ns / 1ps

module bsc_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bsc_pkg::cal_t                  cal,
    input  bsc_pkg::q_stat_t               q_stat,
    input  bsc_pkg::item_t                 q_rd_data,
    output logic                           q_rd_en,
    output bsc_pkg::div_req_t              div_req,
    input  bsc_pkg::div_rsp_t              div_rsp,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bsc_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [0:0]                     m_tuser
);
    import bsc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_T1, ST_DEN, ST_TDIV, ST_SQ, ST_A2, ST_A3, ST_B2L, ST_B2H,
        ST_B1L, ST_B1H, ST_B4, ST_B4F, ST_B4M, ST_B7, ST_PDEN, ST_PDIV,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_OUT
    } state_t;

    state_t                    state_reg;
    logic [RAW_TEMP_W-1:0]     ut_reg;
    logic [RAW_PRESS_W-1:0]    up_reg;
    logic signed [62:0]        prod_reg;
    logic signed [62:0]        tmp_reg;
    logic signed [18:0]        t1_reg;
    logic                      tneg_reg;
    logic signed [28:0]        b6_reg;
    logic [44:0]               sq_reg;
    logic signed [52:0]        b3acc_reg;
    logic signed [44:0]        b4acc_reg;
    logic signed [53:0]        b3_reg;
    logic [31:0]               f_reg;
    logic [31:0]               u_reg;
    logic [32:0]               b4_reg;
    logic                      pdbl_reg;
    logic [PRESS_W-1:0]        ps_reg;
    logic signed [23:0]        pacc_reg;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic [PRESS_W-1:0]        press_reg;
    logic                      err_reg;
    logic                      out_valid_reg;
    logic signed [TEMP_W-1:0]  out_temp_reg;
    logic [PRESS_W-1:0]        out_press_reg;
    logic                      out_err_reg;

    logic signed [33:0]        mul_a;
    logic signed [28:0]        mul_b;

    logic signed [16:0]        diff_t;
    logic signed [18:0]        t1_w;
    logic signed [19:0]        den_w;
    logic signed [26:0]        mcs_w;
    logic [26:0]               num_mag;
    logic [19:0]               den_mag;
    logic signed [27:0]        t2_w;
    logic signed [28:0]        b5_w;
    logic signed [29:0]        tsum_w;
    logic signed [TEMP_W-1:0]  temp_w;
    logic signed [28:0]        b6_w;
    logic signed [63:0]        wide_w;
    logic signed [55:0]        b3v_w;
    logic signed [44:0]        x3_w;
    logic [47:0]               b7_w;
    logic [48:0]               p_w;
    logic signed [25:0]        psum_w;
    logic signed [26:0]        press_w;
    logic                      slot_free;

    // Temperature path
    assign diff_t  = $signed({1'b0, ut_reg}) - $signed({1'b0, cal.ac6});
    assign t1_w    = 19'(prod_reg >>> 15);
    assign den_w   = 20'(t1_w) + 20'(cal.md);
    assign mcs_w   = $signed({cal.mc, 11'b0});
    assign num_mag = mcs_w[26] ? 27'(-mcs_w) : 27'(mcs_w);
    assign den_mag = den_w[19] ? 20'(-den_w) : 20'(den_w);
    assign t2_w    = tneg_reg ? -$signed({1'b0, div_rsp.quo[26:0]})
                              : $signed({1'b0, div_rsp.quo[26:0]});
    assign b5_w    = 29'(t1_reg) + 29'(t2_w);
    assign tsum_w  = (30'(b5_w) + 30'sd8) >>> 4;
    assign b6_w    = b5_w - 29'(B6_OFFSET);

    always_comb begin
        if (tsum_w > 30'sd32767) begin
            temp_w = 16'sh7FFF;
        end else if (tsum_w < -30'sd32768) begin
            temp_w = -16'sh8000;
        end else begin
            temp_w = 16'(tsum_w);
        end
    end

    // Pressure path
    assign wide_w = (64'(prod_reg) <<< 22) + 64'(tmp_reg);
    assign b3v_w  = (56'(b3acc_reg) + (56'(cal.ac1) <<< 2)) <<< cal.oss;
    assign x3_w   = (b4acc_reg + 45'sd2) >>> 2;
    assign b7_w   = prod_reg[47:0];
    assign p_w    = pdbl_reg ? {div_rsp.quo, 1'b0} : {1'b0, div_rsp.quo};
    assign psum_w = 26'(pacc_reg) + 26'(prod_reg >>> 16) + 26'(P_C3);
    assign press_w = $signed({7'b0, ps_reg}) + 27'(psum_w >>> 4);

    assign slot_free = !out_valid_reg || m_tready;
    assign q_rd_en   = (state_reg == ST_IDLE) && !q_stat.empty;

    // Divider requests
    always_comb begin
        div_req = '0;
        if (state_reg == ST_DEN && den_w != '0) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(num_mag) << (DIV_NUM_W - TEMP_DIV_STEPS);
            div_req.den   = DIV_DEN_W'(den_mag);
            div_req.steps = DIV_CNT_W'(TEMP_DIV_STEPS);
        end else if (state_reg == ST_PDEN && b4_reg != '0) begin
            div_req.start = 1'b1;
            div_req.num   = (b7_w < B7_LIMIT) ? {b7_w[DIV_NUM_W-2:0], 1'b0} : b7_w;
            div_req.den   = b4_reg;
            div_req.steps = DIV_CNT_W'(PRESS_DIV_STEPS);
        end
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_T1: begin
                mul_a = 34'(diff_t);
                mul_b = $signed({13'b0, cal.ac5});
            end
            ST_SQ: begin
                mul_a = 34'(b6_reg);
                mul_b = b6_reg;
            end
            ST_A2: begin
                mul_a = 34'(b6_reg);
                mul_b = 29'(cal.ac2);
            end
            ST_A3: begin
                mul_a = 34'(b6_reg);
                mul_b = 29'(cal.ac3);
            end
            ST_B2L: begin
                mul_a = $signed({12'b0, sq_reg[21:0]});
                mul_b = 29'(cal.b2);
            end
            ST_B2H: begin
                mul_a = $signed({11'b0, sq_reg[44:22]});
                mul_b = 29'(cal.b2);
            end
            ST_B1L: begin
                mul_a = $signed({12'b0, sq_reg[21:0]});
                mul_b = 29'(cal.b1);
            end
            ST_B1H: begin
                mul_a = $signed({11'b0, sq_reg[44:22]});
                mul_b = 29'(cal.b1);
            end
            ST_B4M: begin
                mul_a = $signed({2'b0, f_reg});
                mul_b = $signed({13'b0, cal.ac4});
            end
            ST_B7: begin
                mul_a = $signed({2'b0, u_reg});
                mul_b = $signed({13'b0, B7_SCALE >> cal.oss});
            end
            ST_P1: begin
                mul_a = $signed({22'b0, ps_reg[19:8]});
                mul_b = $signed({17'b0, ps_reg[19:8]});
            end
            ST_P2: begin
                mul_a = $signed({10'b0, prod_reg[23:0]});
                mul_b = 29'(P_C1);
            end
            ST_P3: begin
                mul_a = $signed({14'b0, ps_reg});
                mul_b = 29'(P_C2);
            end
            default: ;
        endcase
    end

    // Sequencer, datapath registers and result register
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // Load the result register, or release it once taken
            if ((state_reg == ST_OUT) && slot_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_stat.empty) begin
                        ut_reg    <= q_rd_data.raw_temp;
                        up_reg    <= q_rd_data.raw_press;
                        state_reg <= ST_T1;
                    end
                end
                ST_T1: state_reg <= ST_DEN;
                ST_DEN: begin
                    t1_reg   <= t1_w;
                    tneg_reg <= mcs_w[26] ^ den_w[19];
                    if (den_w == '0) begin
                        temp_reg  <= '0;
                        press_reg <= '0;
                        err_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        err_reg   <= 1'b0;
                        state_reg <= ST_TDIV;
                    end
                end
                ST_TDIV: begin
                    if (div_rsp.done) begin
                        temp_reg  <= temp_w;
                        b6_reg    <= b6_w;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: state_reg <= ST_A2;
                ST_A2: begin
                    sq_reg    <= 45'(prod_reg >>> 12);
                    state_reg <= ST_A3;
                end
                ST_A3: begin
                    b3acc_reg <= 53'(prod_reg >>> 11);
                    state_reg <= ST_B2L;
                end
                ST_B2L: begin
                    b4acc_reg <= 45'(prod_reg >>> 13);
                    state_reg <= ST_B2H;
                end
                ST_B2H: begin
                    tmp_reg   <= prod_reg;
                    state_reg <= ST_B1L;
                end
                ST_B1L: begin
                    b3acc_reg <= b3acc_reg + 53'(wide_w >>> 11);
                    state_reg <= ST_B1H;
                end
                ST_B1H: begin
                    tmp_reg   <= prod_reg;
                    b3_reg    <= 54'((b3v_w + 56'sd2) >>> 2);
                    state_reg <= ST_B4;
                end
                ST_B4: begin
                    b4acc_reg <= b4acc_reg + 45'(wide_w >>> 16);
                    state_reg <= ST_B4F;
                end
                ST_B4F: begin
                    f_reg     <= 32'(x3_w + 45'(B4_OFFSET));
                    u_reg     <= 32'($signed({36'b0, up_reg}) - 55'(b3_reg));
                    state_reg <= ST_B4M;
                end
                ST_B4M: state_reg <= ST_B7;
                ST_B7: begin
                    b4_reg    <= prod_reg[47:15];
                    state_reg <= ST_PDEN;
                end
                ST_PDEN: begin
                    pdbl_reg <= !(b7_w < B7_LIMIT);
                    if (b4_reg == '0) begin
                        press_reg <= '0;
                        err_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_PDIV;
                    end
                end
                ST_PDIV: begin
                    if (div_rsp.done) begin
                        if (p_w > 49'(PRESS_MAX)) begin
                            press_reg <= PRESS_MAX;
                            state_reg <= ST_OUT;
                        end else begin
                            ps_reg    <= p_w[PRESS_W-1:0];
                            state_reg <= ST_P1;
                        end
                    end
                end
                ST_P1: state_reg <= ST_P2;
                ST_P2: state_reg <= ST_P3;
                ST_P3: begin
                    pacc_reg  <= 24'(prod_reg >>> 16);
                    state_reg <= ST_P4;
                end
                ST_P4: begin
                    if (press_w < 0) begin
                        press_reg <= '0;
                    end else if (press_w > $signed({7'b0, PRESS_MAX})) begin
                        press_reg <= PRESS_MAX;
                    end else begin
                        press_reg <= press_w[PRESS_W-1:0];
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (slot_free) begin
                        out_temp_reg  <= temp_reg;
                        out_press_reg <= press_reg;
                        out_err_reg   <= err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - PRESS_W - TEMP_W)'(0), out_press_reg, out_temp_reg};
    assign m_tuser  = out_err_reg;

`ifndef SYNTHESIS
    a_div_done_expected : assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_TDIV) || (state_reg == ST_PDIV))
        else $error("divider finished while no division was awaited");

    a_hold_until_free : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && out_valid_reg && !m_tready |=> state_reg == ST_OUT)
        else $error("result register overwritten before it was taken");
`endif

endmodule

/* hdl/baro_sensor_compensation.sv */
// Top level of the barometer temperature and pressure compensation block.
`timescale 1ns / 1ps
//
// Usage:
//   Write the three packed calibration words and the oversampling setting through
//   cfg_wr_en/cfg_addr/cfg_wdata while the block is idle (index 0..3).
//   Each s_ word carries one raw temperature and one raw pressure reading; each m_
//   word returns temperature in 0.1 degC, pressure in Pa, and m_tuser flags a zero
//   divisor (affected results are then zero).
// Sequencing:
//   The back end works on one word at a time, stepping its sequencer around the
//   shared multiplier and the shared one-bit-per-cycle divider: 27 steps for the
//   temperature division and 48 for the pressure division. A zero divisor ends
//   the word early. The front queues two words while the back works.
// Reset:
//   aresetn (synchronous, active low) clears the calibration registers, the
//   queue, the sequencer and the output valid.
// Backpressure:
//   A finished result waits in the output register while m_tready is low; the
//   back end stops before overwriting it, and s_tready drops once the queue fills.

module baro_sensor_compensation (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // raw_temp[15:0], raw_press[34:16], zero pad
    input  logic [bsc_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // temp_tenths[15:0], press_pa[35:16], zero pad
    output logic [bsc_pkg::M_DATA_W-1:0]       m_tdata,
    // div_error[0]
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [bsc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import bsc_pkg::*;

    cal_t     cal;
    q_stat_t  q_stat;
    logic     q_wr_en;
    item_t    q_wr_data;
    logic     q_rd_en;
    item_t    q_rd_data;
    div_req_t div_req;
    div_rsp_t div_rsp;

    bsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data),
        .cal       (cal)
    );

    bsc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    bsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    bsc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cal       (cal),
        .q_stat    (q_stat),
        .q_rd_data (q_rd_data),
        .q_rd_en   (q_rd_en),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
